FILE: hdl/tfng_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tfng_pkg;

    localparam int POS_W          = 24;
    localparam int NRM_W          = 16;
    localparam int POS_FRAC_BITS_DEF = 16;

    localparam logic [1:0] CFG_SCALE   = 2'd0;
    localparam logic [1:0] CFG_NORMALS = 2'd1;
    localparam logic [1:0] CFG_TEX     = 2'd2;

    typedef struct packed {
        logic signed [POS_W-1:0] in_x;
        logic signed [POS_W-1:0] in_y;
        logic signed [POS_W-1:0] in_z;
        logic                    primitive_end;
    } vin_t;

    typedef struct packed {
        logic signed [POS_W-1:0] out_x;
        logic signed [POS_W-1:0] out_y;
        logic signed [POS_W-1:0] out_z;
        logic signed [NRM_W-1:0] normal_x;
        logic signed [NRM_W-1:0] normal_y;
        logic signed [NRM_W-1:0] normal_z;
        logic signed [POS_W-1:0] tex_u;
        logic signed [POS_W-1:0] tex_v;
        logic                    run_last;
        logic                    primitive_last;
    } vout_t;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } vtx_t;

    // saturate a wide signed value to the position range
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [41:0] v);
        logic signed [41:0] hi;
        logic signed [41:0] lo;
        hi = 42'sd8388607;
        lo = -42'sd8388608;
        if (v > hi)
            sat_pos = 24'sh7FFFFF;
        else if (v < lo)
            sat_pos = 24'sh800000;
        else
            sat_pos = v[POS_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: hdl/tfng_normal.sv
`timescale 1ns / 1ps
`default_nettype none
// Face normal unit: one shared 26x26 multiplier and one shared
// bit-serial sqrt/divide datapath, stepped by a small sequencer.
module tfng_normal
    import tfng_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire vtx_t                    v0,
    input  wire vtx_t                    v1,
    input  wire vtx_t                    v2,
    output logic                         done,
    output logic signed [NRM_W-1:0]      nx,
    output logic signed [NRM_W-1:0]      ny,
    output logic signed [NRM_W-1:0]      nz
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_MAX   = 4'd2;
    localparam logic [3:0] S_NORM  = 4'd3;
    localparam logic [3:0] S_SQ    = 4'd4;
    localparam logic [3:0] S_SQRT  = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_DONE  = 4'd7;

    logic [3:0]                 state_reg, state_next;
    logic [3:0]                 cnt_reg, cnt_next;
    logic [5:0]                 bit_reg, bit_next;
    logic signed [24:0]         e1_reg [3];
    logic signed [24:0]         e2_reg [3];
    logic signed [51:0]         cr_reg [3];
    logic signed [51:0]         cr_next [3];
    logic [50:0]                m_reg [3];
    logic [50:0]                m_next [3];
    logic [50:0]                mx_reg, mx_next;
    logic [49:0]                sum_reg, sum_next;
    logic [49:0]                rem_reg, rem_next;
    logic [24:0]                root_reg, root_next;
    logic [39:0]                dnum_reg, dnum_next;
    logic [40:0]                drem_reg, drem_next;
    logic [15:0]                q_reg, q_next;
    logic [NRM_W-1:0]           n_reg [3];
    logic [NRM_W-1:0]           n_next [3];
    logic signed [51:0]         prod_reg, prod_next;

    // shared multiplier operands
    logic signed [25:0]         mul_a, mul_b;
    logic signed [51:0]         mul_p;
    logic [1:0]                 ci;
    logic [50:0]                sqbase;
    logic [49:0]                trial;
    logic [40:0]                dsh;
    logic [15:0]                qs;

    assign mul_p = mul_a * mul_b;
    assign ci    = cnt_reg[1:0];

    always_comb
    begin
        // six products: cr[k] = e1[a]*e2[b] - e1[b]*e2[a]
        logic [1:0] k, a, b;
        k = cnt_reg[2:1];
        a = (k == 2'd0) ? 2'd1 : (k == 2'd1) ? 2'd2 : 2'd0;
        b = (k == 2'd0) ? 2'd2 : (k == 2'd1) ? 2'd0 : 2'd1;
        mul_a = 26'sd0;
        mul_b = 26'sd0;
        if (state_reg == S_MUL)
        begin
            if (!cnt_reg[0])
            begin
                mul_a = {e1_reg[a][24], e1_reg[a]};
                mul_b = {e2_reg[b][24], e2_reg[b]};
            end
            else
            begin
                mul_a = {e1_reg[b][24], e1_reg[b]};
                mul_b = {e2_reg[a][24], e2_reg[a]};
            end
        end
        else if (state_reg == S_SQ)
        begin
            mul_a = {1'b0, m_reg[ci][24:0]};
            mul_b = {1'b0, m_reg[ci][24:0]};
        end
    end

    always_comb
    begin
        logic [1:0] k;
        k = cnt_reg[2:1];
        state_next = state_reg;
        cnt_next   = cnt_reg;
        bit_next   = bit_reg;
        cr_next    = cr_reg;
        m_next     = m_reg;
        mx_next    = mx_reg;
        sum_next   = sum_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        dnum_next  = dnum_reg;
        drem_next  = drem_reg;
        q_next     = q_reg;
        n_next     = n_reg;
        prod_next  = prod_reg;
        sqbase     = '0;
        trial      = '0;
        dsh        = '0;
        qs         = '0;
        done       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_MUL;
                    cnt_next   = 4'd0;
                end
            end
            S_MUL:
            begin
                if (!cnt_reg[0])
                    prod_next = mul_p;
                else
                    cr_next[k] = prod_reg - mul_p;
                if (cnt_reg == 4'd5)
                begin
                    state_next = S_MAX;
                    cnt_next   = 4'd0;
                end
                else
                    cnt_next = cnt_reg + 4'd1;
            end
            S_MAX:
            begin
                for (int i = 0; i < 3; i++)
                    m_next[i] = cr_reg[i][51] ? 51'(-cr_reg[i]) : 51'(cr_reg[i]);
                mx_next = '0;
                for (int i = 0; i < 3; i++)
                begin
                    if (m_next[i] > mx_next)
                        mx_next = m_next[i];
                end
                if (mx_next == '0)
                begin
                    for (int i = 0; i < 3; i++)
                        n_next[i] = '0;
                    state_next = S_DONE;
                end
                else
                    state_next = S_NORM;
            end
            S_NORM:
            begin
                // one bit of shift per cycle
                if (mx_reg >= 51'd16777216)
                begin
                    mx_next = mx_reg >> 1;
                    for (int i = 0; i < 3; i++)
                        m_next[i] = m_reg[i] >> 1;
                end
                else if (mx_reg < 51'd8388608)
                begin
                    mx_next = mx_reg << 1;
                    for (int i = 0; i < 3; i++)
                        m_next[i] = m_reg[i] << 1;
                end
                else
                begin
                    state_next = S_SQ;
                    cnt_next   = 4'd0;
                    sum_next   = '0;
                end
            end
            S_SQ:
            begin
                sum_next = sum_reg + 50'(mul_p);
                if (cnt_reg == 4'd2)
                begin
                    state_next = S_SQRT;
                    rem_next   = sum_next;
                    root_next  = '0;
                    bit_next   = 6'd24;
                end
                else
                    cnt_next = cnt_reg + 4'd1;
            end
            S_SQRT:
            begin
                // restoring sqrt, one result bit per cycle
                sqbase = {26'd0, root_reg} << (bit_reg + 6'd1);
                trial  = 50'(sqbase) + (50'd1 << (2 * bit_reg));
                if (rem_reg >= trial)
                begin
                    rem_next  = rem_reg - trial;
                    root_next = root_reg | (25'd1 << bit_reg);
                end
                if (bit_reg == 6'd0)
                begin
                    state_next = S_DIV;
                    cnt_next   = 4'd0;
                    dnum_next  = {1'b0, m_reg[0][24:0], 14'd0} + 40'(root_next >> 1);
                    drem_next  = '0;
                    q_next     = '0;
                    bit_next   = 6'd39;
                end
                else
                    bit_next = bit_reg - 6'd1;
            end
            S_DIV:
            begin
                // restoring divide; quotient past 16 bits only saturates
                dsh = {drem_reg[39:0], dnum_reg[bit_reg]};
                qs  = q_reg;
                if (dsh >= {16'd0, root_reg})
                begin
                    drem_next = dsh - {16'd0, root_reg};
                    if (bit_reg > 6'd15)
                        qs = 16'hFFFF;
                    else
                        qs = q_reg | (16'd1 << bit_reg[3:0]);
                end
                else
                    drem_next = dsh;
                q_next = qs;
                if (bit_reg == 6'd0)
                begin
                    n_next[ci] = cr_reg[ci][51]
                        ? NRM_W'(-((qs > 16'd16384) ? 16'd16384 : qs))
                        : ((qs > 16'd16384) ? 16'd16384 : qs);
                    if (ci == 2'd2)
                        state_next = S_DONE;
                    else
                    begin
                        cnt_next  = cnt_reg + 4'd1;
                        dnum_next = {1'b0, m_reg[ci + 2'd1][24:0], 14'd0}
                                  + 40'(root_reg >> 1);
                        drem_next = '0;
                        q_next    = '0;
                        bit_next  = 6'd39;
                    end
                end
                else
                    bit_next = bit_reg - 6'd1;
            end
            S_DONE:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            e1_reg[0] <= 25'(v1.x) - 25'(v0.x);
            e1_reg[1] <= 25'(v1.y) - 25'(v0.y);
            e1_reg[2] <= 25'(v1.z) - 25'(v0.z);
            e2_reg[0] <= 25'(v2.x) - 25'(v0.x);
            e2_reg[1] <= 25'(v2.y) - 25'(v0.y);
            e2_reg[2] <= 25'(v2.z) - 25'(v0.z);
        end
        cnt_reg  <= cnt_next;
        bit_reg  <= bit_next;
        cr_reg   <= cr_next;
        m_reg    <= m_next;
        mx_reg   <= mx_next;
        sum_reg  <= sum_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        dnum_reg <= dnum_next;
        drem_reg <= drem_next;
        q_reg    <= q_next;
        n_reg    <= n_next;
        prod_reg <= prod_next;
    end

    assign nx = n_reg[0];
    assign ny = n_reg[1];
    assign nz = n_reg[2];

endmodule
`default_nettype wire

FILE: hdl/triangle_face_normal_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// Triangle face normal generator. Each request carries one vertex; it is
// scaled by position_scale (Q8.8, round half up, saturated) as it is taken.
// Vertices gather in threes. The third vertex starts the normal unit: six
// products on one shared multiplier, a one-bit-per-cycle normalize shift,
// three squares, a 25-step square root and three 40-step divides. The
// shift runs only as long as the cross product needs it, and a zero
// product skips to zero normals; the block takes no request meanwhile.
// With normals disabled the third vertex goes straight to the output.
// The three vertices then leave one per output request with the shared
// normal (zero when normals are disabled) while the output is not stalled.
// A vertex with primitive_end and an incomplete triangle flushes the
// pending vertices with zero normals.
// Configuration writes are taken at any time but belong while idle.
module triangle_face_normal_generator
    import tfng_pkg::*;
#(
    parameter int POS_FRAC_BITS = POS_FRAC_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire vin_t        in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output vout_t            out_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam logic [1:0] S_IN   = 2'd0;
    localparam logic [1:0] S_NRM  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]              state_reg;
    logic [15:0]             scale_reg;
    logic                    nrm_en_reg;
    logic                    tex_en_reg;
    logic [1:0]              pcnt_reg;
    vtx_t                    pend_reg [2];
    vtx_t                    cur_reg;
    logic                    pe_reg;
    logic [1:0]              ocnt_reg;   // number of results queued
    logic [1:0]              oidx_reg;
    logic                    zero_n_reg;
    vtx_t                    cur_s;
    logic                    acc;
    logic                    nrm_start;
    logic                    nrm_done;
    logic signed [NRM_W-1:0] nx, ny, nz;
    vtx_t                    ov;
    logic                    olast;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IN);
    assign acc       = in_valid && !in_stall;

    // scale: floor((p + 128) / 256), saturated
    always_comb
    begin
        logic signed [41:0] p;
        p = 42'(in_data.in_x) * $signed({26'd0, scale_reg}) + 42'sd128;
        cur_s.x = sat_pos(p >>> 8);
        p = 42'(in_data.in_y) * $signed({26'd0, scale_reg}) + 42'sd128;
        cur_s.y = sat_pos(p >>> 8);
        p = 42'(in_data.in_z) * $signed({26'd0, scale_reg}) + 42'sd128;
        cur_s.z = sat_pos(p >>> 8);
    end

    assign nrm_start = acc && (pcnt_reg == 2'd2) && nrm_en_reg;

    tfng_normal u_normal (
        .clk   (clk),
        .rst_n (rst_n),
        .start (nrm_start),
        .v0    (pend_reg[0]),
        .v1    (pend_reg[1]),
        .v2    (cur_s),
        .done  (nrm_done),
        .nx    (nx),
        .ny    (ny),
        .nz    (nz)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= 16'd256;
            nrm_en_reg <= 1'b1;
            tex_en_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SCALE:   scale_reg  <= cfg_data;
                CFG_NORMALS: nrm_en_reg <= cfg_data[0];
                CFG_TEX:     tex_en_reg <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IN;
            pcnt_reg  <= 2'd0;
            oidx_reg  <= 2'd0;
            ocnt_reg  <= 2'd0;
        end
        else
        begin
            case (state_reg)
                S_IN:
                begin
                    if (acc)
                    begin
                        oidx_reg <= 2'd0;
                        if (pcnt_reg == 2'd2)
                        begin
                            ocnt_reg  <= 2'd3;
                            pcnt_reg  <= 2'd0;
                            state_reg <= nrm_en_reg ? S_NRM : S_OUT;
                        end
                        else if (in_data.primitive_end)
                        begin
                            ocnt_reg  <= pcnt_reg + 2'd1;
                            pcnt_reg  <= 2'd0;
                            state_reg <= S_OUT;
                        end
                        else
                            pcnt_reg <= pcnt_reg + 2'd1;
                    end
                end
                S_NRM:
                begin
                    if (nrm_done)
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        if (oidx_reg + 2'd1 == ocnt_reg)
                            state_reg <= S_IN;
                        oidx_reg <= oidx_reg + 2'd1;
                    end
                end
                default:
                    state_reg <= S_IN;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            cur_reg    <= cur_s;
            pe_reg     <= in_data.primitive_end;
            zero_n_reg <= !(pcnt_reg == 2'd2 && nrm_en_reg);
            if (pcnt_reg != 2'd2 && !in_data.primitive_end)
                pend_reg[pcnt_reg[0]] <= cur_s;
        end
    end

    assign olast = (oidx_reg + 2'd1 == ocnt_reg);
    assign ov    = olast ? cur_reg : pend_reg[oidx_reg[0]];

    always_comb
    begin
        logic signed [24:0] t;
        out_valid = (state_reg == S_OUT);
        out_data.out_x = ov.x;
        out_data.out_y = ov.y;
        out_data.out_z = ov.z;
        out_data.normal_x = zero_n_reg ? '0 : nx;
        out_data.normal_y = zero_n_reg ? '0 : ny;
        out_data.normal_z = zero_n_reg ? '0 : nz;
        t = (25'(ov.x) + (25'sd1 <<< POS_FRAC_BITS)) >>> 1;
        out_data.tex_u = tex_en_reg ? t[POS_W-1:0] : '0;
        t = (25'(ov.y) + (25'sd1 <<< POS_FRAC_BITS)) >>> 1;
        out_data.tex_v = tex_en_reg ? t[POS_W-1:0] : '0;
        out_data.run_last = olast;
        out_data.primitive_last = olast && pe_reg;
    end

endmodule
`default_nettype wire
